/* hw/rtl/psffm_pkg.sv */
// Package for the pump supply and flow fault monitor.
// Holds the transfer payload structs, the register index codes and shared constants.
// No dependencies.
package psffm_pkg;

  localparam int ADC_BITS   = 10;
  localparam int PULSE_BITS = 8;

  localparam int PCT_W      = 7;
  localparam int VOLT_W     = 10;
  localparam int DB_W       = 8;
  localparam int FLOW_W     = 12;
  localparam int TRIP_W     = 8;
  localparam int RUN_W      = 8;
  localparam int SPEED_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Long division: the quotient is below 100, so seven quotient bits suffice.
  localparam int QUO_W      = 7;
  localparam int NUM_W      = 19;
  localparam int CNT_W      = 3;

  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [SPEED_W-1:0] SPEED_FULL = 7'd100;
  localparam logic [RUN_W-1:0]   RUN_MAX    = 8'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_DB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_LIMIT = 3'd7;

  typedef struct packed {
    logic [ADC_BITS-1:0]   supply_sample;
    logic [PULSE_BITS-1:0] pulse_count;
    logic [SPEED_W-1:0]    motor_speed;
  } psffm_in_t;

  typedef struct packed {
    logic [PCT_W-1:0]      voltage_percent;
    logic [PCT_W-1:0]      flow_percent;
    logic [ADC_BITS-1:0]   held_voltage_counts;
    logic [PULSE_BITS-1:0] held_flow_count;
    logic                  undervoltage_trip;
    logic                  underflow_trip;
    logic                  motor_stop;
    logic                  close_all_valves;
    logic                  close_stream_valve;
    logic                  buzzer_on;
  } psffm_out_t;

  // Exact floor(x / 10) for any 12-bit x, by multiplying with a scaled reciprocal.
  function automatic logic [8:0] div10(input logic [FLOW_W-1:0] x);
    logic [27:0] prod;
    prod = 28'(x) * 28'd52429;
    return prod[27:19];
  endfunction

endpackage

/* hw/rtl/pump_supply_flow_fault_monitor.sv */
// Pump supply and flow fault monitor, top level.
// Depends on psffm_pkg for payload structs, register indexes and constants.
//
//  channel  | signals                         | direction | payload
//  ---------+---------------------------------+-----------+---------------------------
//  in       | in_valid, in_ready, in_data     | sink      | psffm_in_t, one period
//  out      | out_valid, out_ready, out_data  | source    | psffm_out_t, one result
//  cfg      | cfg_we, cfg_index, cfg_wdata    | sink      | register write, no wait
//
// After its input transfer, an item passes these steps until its result is loaded into the
// output register: a step to clamp and decide what is taken, a setup step per percent, a
// divider run for each taken percent strictly inside its window, and an update step.
// Reset (rst_n low at a clock edge) restores register defaults and clears control state.
// in_ready rises once the update step has loaded the result, so the next transfer can
// overlap a waiting result; the update step itself stalls while the output register is full.
module pump_supply_flow_fault_monitor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  psffm_pkg::psffm_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output psffm_pkg::psffm_out_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [psffm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psffm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import psffm_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_PSET = 3'd2;
  localparam logic [2:0] S_PDIV = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  // Configuration registers.
  logic [VOLT_W-1:0] vlo_r, vlo_nxt;
  logic [VOLT_W-1:0] vhi_r, vhi_nxt;
  logic [DB_W-1:0]   vdb_r, vdb_nxt;
  logic [FLOW_W-1:0] flo_r, flo_nxt;
  logic [FLOW_W-1:0] fhi_r, fhi_nxt;
  logic [TRIP_W-1:0] trip_r, trip_nxt;
  logic [PCT_W-1:0]  vlim_r, vlim_nxt;
  logic [PCT_W-1:0]  flim_r, flim_nxt;

  // Sequencer and monitor state.
  logic [2:0]            state_r, state_nxt;
  logic                  phase_r, phase_nxt;
  psffm_in_t             in_r, in_nxt;
  logic                  take_v_r, take_v_nxt;
  logic                  take_f_r, take_f_nxt;
  logic                  primed_r, primed_nxt;
  logic [ADC_BITS-1:0]   held_v_r, held_v_nxt;
  logic [PULSE_BITS-1:0] held_f_r, held_f_nxt;
  logic [PCT_W-1:0]      vpct_r, vpct_nxt;
  logic [PCT_W-1:0]      fpct_r, fpct_nxt;
  logic [RUN_W-1:0]      lv_run_r, lv_run_nxt;
  logic [RUN_W-1:0]      lf_run_r, lf_run_nxt;
  logic                  alarm_r, alarm_nxt;

  // Shared long divider.
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] den_sh_r, den_sh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  psffm_out_t out_data_r, out_data_nxt;

  // Combinational helpers.
  logic [ADC_BITS-1:0]   v_clamp;
  logic [ADC_BITS-1:0]   v_diff;
  logic [FLOW_W-1:0]     p_tenths;
  logic [8:0]            f_raw;
  logic [PULSE_BITS-1:0] f_clamp;
  logic [FLOW_W-1:0]     sel_x, sel_lo, sel_hi;
  logic                  sel_take;
  logic                  div_ge;
  logic [QUO_W-1:0]      div_quo;
  logic                  v_bad, f_bad, uv, uf;
  logic                  out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Voltage clamp to the window and distance from the held value.
  always_comb begin
    if (in_r.supply_sample < vlo_r) begin
      v_clamp = vlo_r;
    end else if (in_r.supply_sample > vhi_r) begin
      v_clamp = vhi_r;
    end else begin
      v_clamp = in_r.supply_sample;
    end
    v_diff = (v_clamp > held_v_r) ? (v_clamp - held_v_r) : (held_v_r - v_clamp);
  end

  // Flow clamp: the pulse count is compared in tenths against the window edges.
  always_comb begin
    p_tenths = FLOW_W'(in_r.pulse_count) * FLOW_W'(10);
    if (p_tenths < flo_r) begin
      f_raw = div10(flo_r);
    end else if (p_tenths > fhi_r) begin
      f_raw = div10(fhi_r);
    end else begin
      f_raw = 9'(in_r.pulse_count);
    end
    f_clamp = f_raw[8] ? {PULSE_BITS{1'b1}} : f_raw[PULSE_BITS-1:0];
  end

  // Operand select for the percent step: phase 0 is voltage, phase 1 is flow.
  always_comb begin
    if (!phase_r) begin
      sel_x    = FLOW_W'(held_v_r);
      sel_lo   = FLOW_W'(vlo_r);
      sel_hi   = FLOW_W'(vhi_r);
      sel_take = take_v_r;
    end else begin
      sel_x    = FLOW_W'(held_f_r) * FLOW_W'(10);
      sel_lo   = flo_r;
      sel_hi   = fhi_r;
      sel_take = take_f_r;
    end
  end

  // One restoring division step per cycle.
  assign div_ge  = (rem_r >= den_sh_r);
  assign div_quo = {quo_r[QUO_W-2:0], div_ge};

  // Run counter decisions use the percents as they stand after this period's update.
  always_comb begin
    v_bad = (vpct_r < vlim_r);
    f_bad = (in_r.motor_speed == SPEED_FULL) && (fpct_r < flim_r);
    if (!v_bad) begin
      lv_run_nxt = '0;
    end else begin
      lv_run_nxt = (lv_run_r == RUN_MAX) ? RUN_MAX : lv_run_r + RUN_W'(1);
    end
    if (!f_bad) begin
      lf_run_nxt = '0;
    end else begin
      lf_run_nxt = (lf_run_r == RUN_MAX) ? RUN_MAX : lf_run_r + RUN_W'(1);
    end
    uv = (lv_run_nxt >= trip_r);
    uf = (lf_run_nxt >= trip_r);
  end

  // Configuration writes.
  always_comb begin
    vlo_nxt  = vlo_r;
    vhi_nxt  = vhi_r;
    vdb_nxt  = vdb_r;
    flo_nxt  = flo_r;
    fhi_nxt  = fhi_r;
    trip_nxt = trip_r;
    vlim_nxt = vlim_r;
    flim_nxt = flim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLT_LOW:   vlo_nxt  = cfg_wdata[VOLT_W-1:0];
        REG_VOLT_HIGH:  vhi_nxt  = cfg_wdata[VOLT_W-1:0];
        REG_VOLT_DB:    vdb_nxt  = cfg_wdata[DB_W-1:0];
        REG_FLOW_LOW:   flo_nxt  = cfg_wdata[FLOW_W-1:0];
        REG_FLOW_HIGH:  fhi_nxt  = cfg_wdata[FLOW_W-1:0];
        REG_TRIP_COUNT: trip_nxt = cfg_wdata[TRIP_W-1:0];
        REG_VOLT_LIMIT: vlim_nxt = cfg_wdata[PCT_W-1:0];
        REG_FLOW_LIMIT: flim_nxt = cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    in_nxt        = in_r;
    take_v_nxt    = take_v_r;
    take_f_nxt    = take_f_r;
    primed_nxt    = primed_r;
    held_v_nxt    = held_v_r;
    held_f_nxt    = held_f_r;
    vpct_nxt      = vpct_r;
    fpct_nxt      = fpct_r;
    rem_nxt       = rem_r;
    den_sh_nxt    = den_sh_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    alarm_nxt     = alarm_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // The first period after reset always takes both values.
        take_v_nxt = !primed_r || (v_diff > ADC_BITS'(vdb_r));
        take_f_nxt = !primed_r || (f_clamp != held_f_r);
        if (take_v_nxt) begin
          held_v_nxt = v_clamp;
        end
        if (take_f_nxt) begin
          held_f_nxt = f_clamp;
        end
        primed_nxt = 1'b1;
        phase_nxt  = 1'b0;
        state_nxt  = S_PSET;
      end
      S_PSET: begin
        if (sel_take && (sel_x > sel_lo) && (sel_x < sel_hi)) begin
          // Strictly inside the window: start the divider.
          rem_nxt    = NUM_W'(sel_x - sel_lo) * NUM_W'(100);
          den_sh_nxt = NUM_W'(sel_hi - sel_lo) << (QUO_W - 1);
          quo_nxt    = '0;
          cnt_nxt    = CNT_W'(QUO_W - 1);
          state_nxt  = S_PDIV;
        end else begin
          if (sel_take) begin
            if (!phase_r) begin
              vpct_nxt = (sel_x <= sel_lo) ? '0 : PCT_FULL;
            end else begin
              fpct_nxt = (sel_x <= sel_lo) ? '0 : PCT_FULL;
            end
          end
          phase_nxt = 1'b1;
          state_nxt = phase_r ? S_UPD : S_PSET;
        end
      end
      S_PDIV: begin
        rem_nxt    = div_ge ? (rem_r - den_sh_r) : rem_r;
        den_sh_nxt = den_sh_r >> 1;
        quo_nxt    = div_quo;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (!phase_r) begin
            vpct_nxt = div_quo;
          end else begin
            fpct_nxt = div_quo;
          end
          phase_nxt = 1'b1;
          state_nxt = phase_r ? S_UPD : S_PSET;
        end
      end
      S_UPD: begin
        if (out_free) begin
          alarm_nxt                        = alarm_r || uv || uf;
          out_data_nxt.voltage_percent     = vpct_r;
          out_data_nxt.flow_percent        = fpct_r;
          out_data_nxt.held_voltage_counts = held_v_r;
          out_data_nxt.held_flow_count     = held_f_r;
          out_data_nxt.undervoltage_trip   = uv;
          out_data_nxt.underflow_trip      = uf;
          out_data_nxt.motor_stop          = uv || uf;
          out_data_nxt.close_all_valves    = uv;
          out_data_nxt.close_stream_valve  = uv || uf;
          out_data_nxt.buzzer_on           = alarm_nxt;
          out_valid_nxt                    = 1'b1;
          state_nxt                        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and monitor state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlo_r       <= VOLT_W'(728);
      vhi_r       <= VOLT_W'(849);
      vdb_r       <= DB_W'(20);
      flo_r       <= FLOW_W'(197);
      fhi_r       <= FLOW_W'(1005);
      trip_r      <= TRIP_W'(5);
      vlim_r      <= PCT_W'(5);
      flim_r      <= PCT_W'(25);
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      primed_r    <= 1'b0;
      held_v_r    <= '0;
      held_f_r    <= '0;
      vpct_r      <= '0;
      fpct_r      <= '0;
      lv_run_r    <= '0;
      lf_run_r    <= '0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vlo_r       <= vlo_nxt;
      vhi_r       <= vhi_nxt;
      vdb_r       <= vdb_nxt;
      flo_r       <= flo_nxt;
      fhi_r       <= fhi_nxt;
      trip_r      <= trip_nxt;
      vlim_r      <= vlim_nxt;
      flim_r      <= flim_nxt;
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      primed_r    <= primed_nxt;
      held_v_r    <= held_v_nxt;
      held_f_r    <= held_f_nxt;
      vpct_r      <= vpct_nxt;
      fpct_r      <= fpct_nxt;
      alarm_r     <= alarm_nxt;
      out_valid_r <= out_valid_nxt;
      // The run counters advance once per period, when its result is committed.
      if (state_r == S_UPD && out_free) begin
        lv_run_r <= lv_run_nxt;
        lf_run_r <= lf_run_nxt;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    take_v_r   <= take_v_nxt;
    take_f_r   <= take_f_nxt;
    rem_r      <= rem_nxt;
    den_sh_r   <= den_sh_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // The divider finishes after its last step and hands over to the next percent or update.
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PDIV && cnt_r == '0) |=> (state_r == S_PSET || state_r == S_UPD))
    else $error("divider did not hand over after its last step");

  // Percents written to the result never leave the 0..100 range.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.voltage_percent <= PCT_FULL && out_data.flow_percent <= PCT_FULL))
    else $error("result percent above 100");

  // Once set, the alarm stays set until reset.
  a_alarm_latch: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |=> alarm_r)
    else $error("alarm latch dropped without reset");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting result overwritten");

endmodule
